@@ design/emx_pkg.sv @@
package emx_pkg;

   localparam int OPERAND_BITS_DEF = 128;

   localparam logic [1:0] CMD_KEYGEN  = 2'd0;
   localparam logic [1:0] CMD_ENCRYPT = 2'd1;
   localparam logic [1:0] CMD_DECRYPT = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOD_LO = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOD_HI = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GEN_LO = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GEN_HI = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEC_LO = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEC_HI = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] first_low;
      logic [63:0] first_high;
      logic [63:0] second_low;
      logic [63:0] second_high;
   } req_word_type;

   typedef struct packed {
      logic [63:0] out_a_low;
      logic [63:0] out_a_high;
      logic [63:0] out_b_low;
      logic [63:0] out_b_high;
      logic        error;
   } rsp_word_type;

endpackage

@@ design/elgamal_modexp_engine_top.sv @@
// Channel   Ports                                   Handshake
// request   start, busy, req_word                   taken when start & !busy
// response  rsp_valid, rsp_word                     one-cycle strobe, no stall
// csr       csr_valid, csr_ready, csr_index/data    write when valid & ready
//
// One word at a time; busy stays high through the response strobe.
// Each modular multiply is bit-serial through one shared add/compare unit:
// a doubling per multiplier bit, plus an add where that bit is set.
// An exponentiation takes up to 2W multiplies (W = OPERAND_BITS); a word runs
// one to two exponentiations plus, on decrypt, an extended-Euclid inverse whose
// steps each run a W-bit restoring divide, then one multiply.
// Synchronous reset clears control, csr and public key; the receiver cannot stall.
module elgamal_modexp_engine_top #(
   parameter int OPERAND_BITS = emx_pkg::OPERAND_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  emx_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   output emx_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [emx_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [63:0]                         csr_data
);
   import emx_pkg::*;

   localparam int W  = OPERAND_BITS;
   localparam int IW = (W > 1) ? $clog2(W) : 1;
   localparam logic [IW-1:0] TOP_BIT = IW'(W - 1);
   localparam logic [W-1:0]  ONE     = W'(1);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_MUL     = 5'd1;
   localparam logic [4:0] S_EXP_RED = 5'd2;
   localparam logic [4:0] S_EXP_BIT = 5'd3;
   localparam logic [4:0] S_EXP_ACC = 5'd4;
   localparam logic [4:0] S_EXP_SQ  = 5'd5;
   localparam logic [4:0] S_EXP_SQD = 5'd6;
   localparam logic [4:0] S_EXP_END = 5'd7;
   localparam logic [4:0] S_INV_CHK = 5'd8;
   localparam logic [4:0] S_DIV     = 5'd9;
   localparam logic [4:0] S_INV_Q   = 5'd10;
   localparam logic [4:0] S_INV_UPD = 5'd11;
   localparam logic [4:0] S_FIN_ENC = 5'd12;
   localparam logic [4:0] S_FIN_DEC = 5'd13;
   localparam logic [4:0] S_OUT     = 5'd14;

   logic [4:0]   state_ff, state_in, ret_ff, ret_in;
   logic [1:0]   cmd_ff, cmd_in;
   logic         stage_ff, stage_in;
   logic [63:0]  cfg_ff [6];
   logic [63:0]  cfg_in [6];
   logic [W-1:0] pk_ff, pk_in;
   logic [W-1:0] first_ff, first_in, second_ff, second_in;
   logic [W-1:0] ma_ff, ma_in, mb_ff, mb_in, mr_ff, mr_in;
   logic [IW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic         half_ff, half_in;
   logic [W-1:0] base_ff, base_in, acc_ff, acc_in, exp_ff, exp_in;
   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0] q_ff, q_in, rem_ff, rem_in;
   logic [W-1:0] oa_ff, oa_in, ob_ff, ob_in;
   logic         err_ff, err_in;

   logic [127:0] mod_full, gen_full, sec_full, first_full, second_full;
   logic [W-1:0] mod_w, gen_w, sec_w;
   logic         small_mod;
   logic [W:0]   add_sum, add_red;
   logic [W-1:0] add_y, add_out;
   logic [W:0]   div_sh, div_diff;
   logic [W:0]   t_diff;
   logic [W-1:0] t_new;

   assign mod_full    = {cfg_ff[1], cfg_ff[0]};
   assign gen_full    = {cfg_ff[3], cfg_ff[2]};
   assign sec_full    = {cfg_ff[5], cfg_ff[4]};
   assign first_full  = {req_word.first_high, req_word.first_low};
   assign second_full = {req_word.second_high, req_word.second_low};
   assign mod_w = mod_full[W-1:0];
   assign gen_w = gen_full[W-1:0];
   assign sec_w = sec_full[W-1:0];
   assign small_mod = (mod_w == '0) || (mod_w == ONE);

   // shared modular adder: mr + (mr or ma) mod p, inputs below p
   assign add_y   = half_ff ? ma_ff : mr_ff;
   assign add_sum = {1'b0, mr_ff} + {1'b0, add_y};
   assign add_red = add_sum - {1'b0, mod_w};
   assign add_out = (add_sum >= {1'b0, mod_w}) ? add_red[W-1:0] : add_sum[W-1:0];

   // restoring division step
   assign div_sh   = {rem_ff, r0_ff[cnt_ff]};
   assign div_diff = div_sh - {1'b0, r1_ff};

   // t0 - q*t1 mod p
   assign t_diff = {1'b0, t0_ff} - {1'b0, mr_ff};
   assign t_new  = t_diff[W] ? W'(t_diff[W-1:0] + mod_w) : t_diff[W-1:0];

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      logic [127:0] oa_full, ob_full;
      oa_full = 128'(oa_ff);
      ob_full = 128'(ob_ff);
      rsp_word.out_a_low  = oa_full[63:0];
      rsp_word.out_a_high = oa_full[127:64];
      rsp_word.out_b_low  = ob_full[63:0];
      rsp_word.out_b_high = ob_full[127:64];
      rsp_word.error      = err_ff;
   end

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  cmd_in = cmd_ff;  stage_in = stage_ff;
      cfg_in = cfg_ff;  pk_in = pk_ff;
      first_in = first_ff;  second_in = second_ff;
      ma_in = ma_ff;  mb_in = mb_ff;  mr_in = mr_ff;  cnt_in = cnt_ff;  half_in = half_ff;
      base_in = base_ff;  acc_in = acc_ff;  exp_in = exp_ff;  idx_in = idx_ff;
      r0_in = r0_ff;  r1_in = r1_ff;  t0_in = t0_ff;  t1_in = t1_ff;
      q_in = q_ff;  rem_in = rem_ff;
      oa_in = oa_ff;  ob_in = ob_ff;  err_in = err_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOD_LO: cfg_in[0] = csr_data;
            CSR_MOD_HI: cfg_in[1] = csr_data;
            CSR_GEN_LO: cfg_in[2] = csr_data;
            CSR_GEN_HI: cfg_in[3] = csr_data;
            CSR_SEC_LO: cfg_in[4] = csr_data;
            CSR_SEC_HI: cfg_in[5] = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_word.command;
               first_in  = first_full[W-1:0];
               second_in = second_full[W-1:0];
               stage_in  = 1'b0;
               oa_in = '0;  ob_in = '0;  err_in = 1'b0;
               if (req_word.command == CMD_UNUSED || small_mod) begin
                  err_in = (req_word.command == CMD_DECRYPT);
                  if (req_word.command == CMD_KEYGEN) pk_in = '0;
                  state_in = S_OUT;
               end else begin
                  // reduce base first: 1 * base mod p
                  ma_in  = ONE;
                  mb_in  = (req_word.command == CMD_DECRYPT) ? second_full[W-1:0] : gen_w;
                  exp_in = (req_word.command == CMD_ENCRYPT) ? second_full[W-1:0] : sec_w;
                  mr_in = '0;  cnt_in = TOP_BIT;  half_in = 1'b0;
                  ret_in = S_EXP_RED;  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            mr_in = add_out;
            if (!half_ff && mb_ff[cnt_ff]) begin
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               if (cnt_ff == '0) state_in = ret_ff;
               else cnt_in = cnt_ff - 1'b1;
            end
         end
         S_EXP_RED: begin
            base_in = mr_ff;  acc_in = ONE;  idx_in = '0;
            state_in = S_EXP_BIT;
         end
         S_EXP_BIT: begin
            if (exp_ff[idx_ff]) begin
               ma_in = acc_ff;  mb_in = base_ff;
               mr_in = '0;  cnt_in = TOP_BIT;  half_in = 1'b0;
               ret_in = S_EXP_ACC;  state_in = S_MUL;
            end else begin
               state_in = S_EXP_SQ;
            end
         end
         S_EXP_ACC: begin
            acc_in = mr_ff;
            state_in = S_EXP_SQ;
         end
         S_EXP_SQ: begin
            if (idx_ff == TOP_BIT) begin
               state_in = S_EXP_END;   // last square is never used
            end else begin
               ma_in = base_ff;  mb_in = base_ff;
               mr_in = '0;  cnt_in = TOP_BIT;  half_in = 1'b0;
               ret_in = S_EXP_SQD;  state_in = S_MUL;
            end
         end
         S_EXP_SQD: begin
            base_in = mr_ff;  idx_in = idx_ff + 1'b1;
            state_in = S_EXP_BIT;
         end
         S_EXP_END: begin
            case (cmd_ff)
               CMD_KEYGEN: begin
                  oa_in = acc_ff;  pk_in = acc_ff;
                  state_in = S_OUT;
               end
               CMD_ENCRYPT: begin
                  if (!stage_ff) begin
                     oa_in = acc_ff;  stage_in = 1'b1;
                     ma_in = ONE;  mb_in = pk_ff;  exp_in = second_ff;
                     mr_in = '0;  cnt_in = TOP_BIT;  half_in = 1'b0;
                     ret_in = S_EXP_RED;  state_in = S_MUL;
                  end else begin
                     ma_in = acc_ff;  mb_in = first_ff;
                     mr_in = '0;  cnt_in = TOP_BIT;  half_in = 1'b0;
                     ret_in = S_FIN_ENC;  state_in = S_MUL;
                  end
               end
               default: begin
                  r0_in = mod_w;  r1_in = acc_ff;  t0_in = '0;  t1_in = ONE;
                  state_in = S_INV_CHK;
               end
            endcase
         end
         S_INV_CHK: begin
            if (r1_ff == '0) begin
               if (r0_ff == ONE) begin
                  ma_in = t0_ff;  mb_in = first_ff;
                  mr_in = '0;  cnt_in = TOP_BIT;  half_in = 1'b0;
                  ret_in = S_FIN_DEC;  state_in = S_MUL;
               end else begin
                  err_in = 1'b1;  oa_in = '0;
                  state_in = S_OUT;
               end
            end else begin
               q_in = '0;  rem_in = '0;  cnt_in = TOP_BIT;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_diff[W]) begin
               rem_in = div_diff[W-1:0];
               q_in   = {q_ff[W-2:0], 1'b1};
            end else begin
               rem_in = div_sh[W-1:0];
               q_in   = {q_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == '0) state_in = S_INV_Q;
            else cnt_in = cnt_ff - 1'b1;
         end
         S_INV_Q: begin
            ma_in = t1_ff;  mb_in = q_ff;
            mr_in = '0;  cnt_in = TOP_BIT;  half_in = 1'b0;
            ret_in = S_INV_UPD;  state_in = S_MUL;
         end
         S_INV_UPD: begin
            r0_in = r1_ff;  r1_in = rem_ff;
            t0_in = t1_ff;  t1_in = t_new;
            state_in = S_INV_CHK;
         end
         S_FIN_ENC: begin
            ob_in = mr_ff;
            state_in = S_OUT;
         end
         S_FIN_DEC: begin
            oa_in = mr_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         for (int i = 0; i < 6; i++) cfg_ff[i] <= '0;
         pk_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cfg_ff   <= cfg_in;
         pk_ff    <= pk_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  stage_ff <= stage_in;
      first_ff <= first_in;  second_ff <= second_in;
      ma_ff <= ma_in;  mb_ff <= mb_in;  mr_ff <= mr_in;
      cnt_ff <= cnt_in;  half_ff <= half_in;
      base_ff <= base_in;  acc_ff <= acc_in;  exp_ff <= exp_in;  idx_ff <= idx_in;
      r0_ff <= r0_in;  r1_ff <= r1_in;  t0_ff <= t0_in;  t1_ff <= t1_in;
      q_ff <= q_in;  rem_ff <= rem_in;
      oa_ff <= oa_in;  ob_ff <= ob_in;  err_ff <= err_in;
   end

endmodule
